[design/fcal_pkg.sv]
// Shared types and constants of the first-fit free-list allocator.
`timescale 1ns / 1ps
package fcal_pkg;

  localparam int unsigned POOL_UNITS = 4096;
  localparam int unsigned UNIT_BYTES = 16;
  localparam int unsigned UNIT_SHIFT = $clog2(UNIT_BYTES);
  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned ALU_W      = 14;

  localparam logic [SIZE_W-1:0] MAX_STEPS  = SIZE_W'(POOL_UNITS);
  localparam logic [ALU_W-1:0]  POOL_LIMIT = ALU_W'(POOL_UNITS);
  localparam logic [SIZE_W-1:0] RESET_GROWTH = 13'd1024;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [16:0] {
    S_IDLE    = 17'b00000000000000001,
    S_FW_INIT = 17'b00000000000000010,
    S_FW_RD   = 17'b00000000000000100,
    S_FW_DAT  = 17'b00000000000001000,
    S_FM_RD   = 17'b00000000000010000,
    S_FM_RD2  = 17'b00000000000100000,
    S_FM_DAT  = 17'b00000000001000000,
    S_FP_RD   = 17'b00000000010000000,
    S_FP_DAT  = 17'b00000000100000000,
    S_FP_MRG  = 17'b00000001000000000,
    S_TK_INIT = 17'b00000010000000000,
    S_TK_RD   = 17'b00000100000000000,
    S_TK_DAT  = 17'b00001000000000000,
    S_TK_SPLT = 17'b00010000000000000,
    S_GR_LOOP = 17'b00100000000000000,
    S_GR_CHK  = 17'b01000000000000000,
    S_DONE    = 17'b10000000000000000
  } state_e;

  // Request to the shared adder/subtractor.
  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

endpackage

[design/first_fit_free_list_allocator.sv]
// Top level of the first-fit free-list allocator with coalescing.
//
//  Channel   | Direction | Handshake                      | Payload
//  ----------+-----------+--------------------------------+-------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready  | tuser: op; tdata: size, address
//  m_axis    | out       | m_axis_tvalid / m_axis_tready  | tuser: ok; tdata: address, count
//  cfg       | in        | cfg_valid_i / cfg_ready_o      | growth chunk in units
//
// Walks: each free-list entry that a walk visits is one read of the header memories.
// An allocation that grows the pool adds the summing of growth chunks, a release walk
// and a second first-fit walk.
// Reset: asynchronous and active low. It clears the control state, the sentinel link and
// the free block count at once and sets the pool break to one; the header memories need no clear.
// Stalls: the input is taken only while the sequencer is idle, and one finished result
// may wait in the output register while the next transaction is being accepted.
`timescale 1ns / 1ps
module first_fit_free_list_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [16:0] size_bytes, [28:17] address, rest zero
  input  logic        s_axis_tuser,   // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [11:0] block_address, [23:12] free_block_count
  output logic        m_axis_tuser,   // [0] ok
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [12:0] cfg_data_i      // growth_chunk_units
);
  import fcal_pkg::*;

  state_e state_q, state_d;

  logic [ADDR_W-1:0] cur_q, cur_d, prev_q, prev_d, hdr_q, hdr_d, hn_q, hn_d;
  logic [ADDR_W-1:0] sent_q, sent_d;
  logic [SIZE_W-1:0] steps_q, steps_d, sh_q, sh_d, sp_q, sp_d, diff_q, diff_d;
  logic [SIZE_W-1:0] res_q, res_d, nh_q, nh_d, pb_q, pb_d, growth_q;
  logic [ALU_W-1:0]  end_q, end_d, chunk_q, chunk_d;
  logic [ADDR_W-1:0] free_q, free_d;
  logic              ok_q, ok_d, op_q, op_d, grown_q, grown_d;

  logic              m_valid_q, m_valid_d;
  logic [ADDR_W-1:0] m_addr_q, m_addr_d, m_cnt_q, m_cnt_d;
  logic              m_ok_q, m_ok_d;

  // Header memories: block size and link to the next free block.
  logic              sz_we, nx_we;
  logic [ADDR_W-1:0] sz_waddr, sz_raddr, nx_waddr, nx_raddr;
  logic [SIZE_W-1:0] sz_wdata, sz_rdata;
  logic [ADDR_W-1:0] nx_wdata, nx_rdata;

  alu_req_t          alu_req;
  logic [ALU_W:0]    alu_y;

  logic [SIZE_W-1:0] g_eff;
  logic [ADDR_W-1:0] in_addr;
  logic [16:0]       in_size;
  logic [16:0]       nh_full;
  state_e            rel_end;

  fcal_ram #(.WIDTH(SIZE_W), .DEPTH(POOL_UNITS)) u_size_ram (
    .clk_i  (clk_i),
    .we_i   (sz_we),
    .waddr_i(sz_waddr),
    .wdata_i(sz_wdata),
    .raddr_i(sz_raddr),
    .rdata_o(sz_rdata)
  );

  fcal_ram #(.WIDTH(ADDR_W), .DEPTH(POOL_UNITS)) u_next_ram (
    .clk_i  (clk_i),
    .we_i   (nx_we),
    .waddr_i(nx_waddr),
    .wdata_i(nx_wdata),
    .raddr_i(nx_raddr),
    .rdata_o(nx_rdata)
  );

  fcal_alu u_alu (
    .req_i(alu_req),
    .y_o  (alu_y)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_cnt_q, m_addr_q};
  assign m_axis_tuser  = m_ok_q;

  assign in_size = s_axis_tdata[16:0];
  assign in_addr = s_axis_tdata[28:17];
  // One header unit plus the payload rounded up to whole units.
  assign nh_full = ((in_size - 17'd1) >> UNIT_SHIFT) + 17'd2;
  // A growth chunk of zero behaves as one unit.
  assign g_eff   = (growth_q == '0) ? SIZE_W'(1) : growth_q;
  // After a release, an allocation goes on to the second first-fit walk.
  assign rel_end = (op_q == OP_ALLOC) ? S_TK_INIT : S_DONE;

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    hdr_d     = hdr_q;
    hn_d      = hn_q;
    sent_d    = sent_q;
    steps_d   = steps_q;
    sh_d      = sh_q;
    sp_d      = sp_q;
    diff_d    = diff_q;
    res_d     = res_q;
    nh_d      = nh_q;
    pb_d      = pb_q;
    end_d     = end_q;
    chunk_d   = chunk_q;
    free_d    = free_q;
    ok_d      = ok_q;
    op_d      = op_q;
    grown_d   = grown_q;
    m_valid_d = m_valid_q;
    m_addr_d  = m_addr_q;
    m_cnt_d   = m_cnt_q;
    m_ok_d    = m_ok_q;
    sz_we     = 1'b0;
    sz_waddr  = hdr_q;
    sz_wdata  = sh_q;
    sz_raddr  = cur_q;
    nx_we     = 1'b0;
    nx_waddr  = hdr_q;
    nx_wdata  = hn_q;
    nx_raddr  = cur_q;
    alu_req   = '{a: '0, b: '0, sub: 1'b0};

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d = s_axis_tuser;
          if (s_axis_tuser == OP_ALLOC) begin
            if (in_size == '0) begin
              ok_d    = 1'b0;
              state_d = S_DONE;
            end else begin
              // Unit counts past the 13-bit range saturate; nothing can hold them.
              nh_d    = (nh_full[16:SIZE_W] != '0) ? '1 : nh_full[SIZE_W-1:0];
              grown_d = 1'b0;
              state_d = S_TK_INIT;
            end
          end else if (in_addr != '0 &&
                       {1'b0, in_addr - ADDR_W'(1)} < pb_q) begin
            hdr_d   = in_addr - ADDR_W'(1);
            ok_d    = 1'b1;
            state_d = S_FW_INIT;
          end else begin
            ok_d    = 1'b0;
            state_d = S_DONE;
          end
        end
      end

      // Release walk: find the last free block at or below the header.
      S_FW_INIT: begin
        prev_d  = '0;
        cur_d   = sent_q;
        steps_d = '0;
        state_d = S_FW_RD;
      end
      S_FW_RD: begin
        if (cur_q != '0 && cur_q <= hdr_q && steps_q <= MAX_STEPS) begin
          state_d = S_FW_DAT;
        end else begin
          state_d = S_FM_RD;
        end
      end
      S_FW_DAT: begin
        prev_d  = cur_q;
        cur_d   = nx_rdata;
        steps_d = steps_q + SIZE_W'(1);
        state_d = S_FW_RD;
      end

      // Merge with the following free block.
      S_FM_RD: begin
        free_d   = free_q + ADDR_W'(1);
        sz_raddr = hdr_q;
        state_d  = S_FM_RD2;
      end
      S_FM_RD2: begin
        // The sentinel always has size zero.
        sh_d        = (hdr_q == '0) ? '0 : sz_rdata;
        alu_req.a   = ALU_W'(hdr_q);
        alu_req.b   = (hdr_q == '0) ? '0 : ALU_W'(sz_rdata);
        end_d       = alu_y[ALU_W-1:0];
        state_d     = S_FM_DAT;
      end
      S_FM_DAT: begin
        if (cur_q != '0 && end_q == ALU_W'(cur_q)) begin
          alu_req.a = ALU_W'(sh_q);
          alu_req.b = ALU_W'(sz_rdata);
          sz_we     = 1'b1;
          sz_waddr  = hdr_q;
          sz_wdata  = alu_y[SIZE_W-1:0];
          sh_d      = alu_y[SIZE_W-1:0];
          hn_d      = nx_rdata;
          free_d    = free_q - ADDR_W'(1);
        end else begin
          hn_d      = cur_q;
        end
        if (hdr_q == '0) begin
          sent_d = hn_d;
        end else begin
          nx_we    = 1'b1;
          nx_waddr = hdr_q;
          nx_wdata = hn_d;
        end
        state_d = S_FP_RD;
      end

      // Merge with the preceding free block, or link it to the new one.
      S_FP_RD: begin
        if (prev_q == '0) begin
          sent_d  = hdr_q;
          state_d = rel_end;
        end else begin
          sz_raddr = prev_q;
          state_d  = S_FP_DAT;
        end
      end
      S_FP_DAT: begin
        sp_d      = sz_rdata;
        alu_req.a = ALU_W'(prev_q);
        alu_req.b = ALU_W'(sz_rdata);
        if (alu_y[ALU_W-1:0] == ALU_W'(hdr_q)) begin
          state_d = S_FP_MRG;
        end else begin
          nx_we    = 1'b1;
          nx_waddr = prev_q;
          nx_wdata = hdr_q;
          state_d  = rel_end;
        end
      end
      S_FP_MRG: begin
        alu_req.a = ALU_W'(sp_q);
        alu_req.b = ALU_W'(sh_q);
        sz_we     = 1'b1;
        sz_waddr  = prev_q;
        sz_wdata  = alu_y[SIZE_W-1:0];
        nx_we     = 1'b1;
        nx_waddr  = prev_q;
        nx_wdata  = hn_q;
        free_d    = free_q - ADDR_W'(1);
        state_d   = rel_end;
      end

      // First-fit walk.
      S_TK_INIT: begin
        prev_d  = '0;
        cur_d   = sent_q;
        steps_d = '0;
        state_d = S_TK_RD;
      end
      S_TK_RD: begin
        if (cur_q == '0 || steps_q > MAX_STEPS) begin
          if (!grown_q) begin
            chunk_d = '0;
            state_d = S_GR_LOOP;
          end else begin
            ok_d    = 1'b0;
            state_d = S_DONE;
          end
        end else begin
          state_d = S_TK_DAT;
        end
      end
      S_TK_DAT: begin
        alu_req.a   = ALU_W'(sz_rdata);
        alu_req.b   = ALU_W'(nh_q);
        alu_req.sub = 1'b1;
        if (!alu_y[ALU_W]) begin
          if (alu_y[ALU_W-1:0] == '0) begin
            // Exact fit: unlink the block.
            if (prev_q == '0) begin
              sent_d = nx_rdata;
            end else begin
              nx_we    = 1'b1;
              nx_waddr = prev_q;
              nx_wdata = nx_rdata;
            end
            free_d  = free_q - ADDR_W'(1);
            res_d   = SIZE_W'(cur_q);
            ok_d    = 1'b1;
            state_d = S_DONE;
          end else begin
            // Split: shrink the block and take the request from its tail.
            diff_d   = alu_y[SIZE_W-1:0];
            sz_we    = 1'b1;
            sz_waddr = cur_q;
            sz_wdata = alu_y[SIZE_W-1:0];
            state_d  = S_TK_SPLT;
          end
        end else begin
          prev_d  = cur_q;
          cur_d   = nx_rdata;
          steps_d = steps_q + SIZE_W'(1);
          state_d = S_TK_RD;
        end
      end
      S_TK_SPLT: begin
        alu_req.a = ALU_W'(cur_q);
        alu_req.b = ALU_W'(diff_q);
        if (alu_y[ALU_W-1:ADDR_W] == '0) begin
          sz_we    = 1'b1;
          sz_waddr = alu_y[ADDR_W-1:0];
          sz_wdata = nh_q;
        end
        res_d   = alu_y[SIZE_W-1:0];
        ok_d    = 1'b1;
        state_d = S_DONE;
      end

      // Pool growth: round the request up to whole chunks, one add a cycle.
      S_GR_LOOP: begin
        if (chunk_q >= ALU_W'(nh_q)) begin
          state_d = S_GR_CHK;
        end else begin
          alu_req.a = chunk_q;
          alu_req.b = ALU_W'(g_eff);
          chunk_d   = alu_y[ALU_W-1:0];
        end
      end
      S_GR_CHK: begin
        alu_req.a = ALU_W'(pb_q);
        alu_req.b = chunk_q;
        if (alu_y <= {1'b0, POOL_LIMIT}) begin
          sz_we    = 1'b1;
          sz_waddr = pb_q[ADDR_W-1:0];
          sz_wdata = chunk_q[SIZE_W-1:0];
          nx_we    = 1'b1;
          nx_waddr = pb_q[ADDR_W-1:0];
          nx_wdata = '0;
          hdr_d    = pb_q[ADDR_W-1:0];
          pb_d     = alu_y[SIZE_W-1:0];
          grown_d  = 1'b1;
          state_d  = S_FW_INIT;
        end else begin
          ok_d    = 1'b0;
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_ok_d    = ok_q;
          m_cnt_d   = free_q;
          m_addr_d  = (op_q == OP_ALLOC && ok_q) ? res_q[ADDR_W-1:0] + ADDR_W'(1) : '0;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // The read addresses follow the walk pointer unless a state overrides them.
    if (state_q == S_FW_RD) begin
      nx_raddr = cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      sent_q    <= '0;
      pb_q      <= SIZE_W'(1);
      free_q    <= '0;
      growth_q  <= RESET_GROWTH;
      m_valid_q <= 1'b0;
      op_q      <= OP_ALLOC;
      ok_q      <= 1'b0;
      grown_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      sent_q    <= sent_d;
      pb_q      <= pb_d;
      free_q    <= free_d;
      m_valid_q <= m_valid_d;
      op_q      <= op_d;
      ok_q      <= ok_d;
      grown_q   <= grown_d;
      if (cfg_valid_i) begin
        growth_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    hdr_q    <= hdr_d;
    hn_q     <= hn_d;
    steps_q  <= steps_d;
    sh_q     <= sh_d;
    sp_q     <= sp_d;
    diff_q   <= diff_d;
    res_q    <= res_d;
    nh_q     <= nh_d;
    end_q    <= end_d;
    chunk_q  <= chunk_d;
    m_addr_q <= m_addr_d;
    m_cnt_q  <= m_cnt_d;
    m_ok_q   <= m_ok_d;
  end

endmodule

[design/fcal_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fcal_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/fcal_alu.sv]
// Shared adder/subtractor of the allocator; bit 14 of the result is carry or borrow.
`timescale 1ns / 1ps
module fcal_alu (
  input  fcal_pkg::alu_req_t        req_i,
  output logic [fcal_pkg::ALU_W:0]  y_o
);
  import fcal_pkg::*;

  always_comb begin
    if (req_i.sub) begin
      y_o = {1'b0, req_i.a} - {1'b0, req_i.b};
    end else begin
      y_o = {1'b0, req_i.a} + {1'b0, req_i.b};
    end
  end

endmodule

[design/fcal_checker.sv]
// Port-level checks of the allocator, bound to its top level.
`timescale 1ns / 1ps
module fcal_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A waiting result keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A result with ok low carries address zero.
  a_fail_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[11:0] == 12'd0)
    else $error("failed transaction reports an address");

  // The engine is busy in the cycle after it takes a transaction.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken twice in a row");

  // No result is offered while reset is held.
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind first_fit_free_list_allocator fcal_checker u_fcal_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
